/* hdl/sdis_pkg.sv */
// ----------------------------------------------------------------------------
// sdis_pkg
// Types, register indexes, phase codes and reset values for the step-dock
// impact sequencer.
// ----------------------------------------------------------------------------
package sdis_pkg;

    localparam int LEN_W      = 14;
    localparam int HEAD_TOL_W = 12;
    localparam int HEAD_W     = 13;
    localparam int SPEED_W    = 16;
    localparam int LIMIT_W    = 15;
    localparam int TICK_W     = 16;
    localparam int HOLD_W     = 20;
    localparam int PHASE_W    = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_PREPARE_LENGTH    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LENGTH_TOLERANCE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADING_TOLERANCE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_FORWARD_SPEED = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_DELTA_LIMIT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MISMATCH_LIMIT    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CONFIRM_TIME      = 3'd6;

    localparam logic [PHASE_W-1:0] PHASE_INACTIVE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_PREPARE  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_PASSIVE  = 2'd2;

    localparam logic [LEN_W-1:0]          RST_PREPARE_LENGTH    = 14'd3800;
    localparam logic [LEN_W-1:0]          RST_LENGTH_TOLERANCE  = 14'd200;
    localparam logic [HEAD_TOL_W-1:0]     RST_HEADING_TOLERANCE = 12'd87;
    localparam logic signed [SPEED_W-1:0] RST_MIN_FORWARD_SPEED = 16'sd300;
    localparam logic [LIMIT_W-1:0]        RST_RATE_DELTA_LIMIT  = 15'd500;
    localparam logic [LIMIT_W-1:0]        RST_MISMATCH_LIMIT    = 15'd120;
    localparam logic [HOLD_W-1:0]         RST_CONFIRM_TIME      = 20'd2000;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    // Declared from the highest bits down so that bit 0 is dock_requested.
    typedef struct packed {
        logic [2:0]                pad;
        logic [TICK_W-1:0]         tick_length;
        logic signed [SPEED_W-1:0] wheel_imu_mismatch;
        logic signed [SPEED_W-1:0] right_rate_delta;
        logic signed [SPEED_W-1:0] left_rate_delta;
        logic                      impact_window_ok;
        logic [LEN_W-1:0]          right_length;
        logic [LEN_W-1:0]          left_length;
        logic signed [HEAD_W-1:0]  heading_err;
        logic signed [SPEED_W-1:0] forward_speed;
        logic                      speed_reliable;
        logic                      on_ground;
        logic                      dock_requested;
    } in_item_t;

    typedef struct packed {
        logic              pad;
        logic [HOLD_W-1:0] hold_elapsed;
        logic              armed;
        logic [PHASE_W-1:0] task_phase;
    } out_item_t;

    // Magnitude of a 16-bit value, saturated at 32767.
    function automatic logic [LIMIT_W-1:0] abs16(input logic signed [SPEED_W-1:0] v);
        logic [SPEED_W-1:0] mag;
        mag = v[SPEED_W-1] ? (~v + 1'b1) : v;
        return mag[SPEED_W-1] ? {LIMIT_W{1'b1}} : mag[LIMIT_W-1:0];
    endfunction

    // Magnitude of a 13-bit value, saturated at 4095.
    function automatic logic [HEAD_TOL_W-1:0] abs13(input logic signed [HEAD_W-1:0] v);
        logic [HEAD_W-1:0] mag;
        mag = v[HEAD_W-1] ? (~v + 1'b1) : v;
        return mag[HEAD_W-1] ? {HEAD_TOL_W{1'b1}} : mag[HEAD_TOL_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] len_diff(input logic [LEN_W-1:0] a,
                                                  input logic [LEN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* hdl/step_dock_impact_sequencer.sv */
// ----------------------------------------------------------------------------
// step_dock_impact_sequencer
// Inactive / prepare / impact-passive sequencer, one control tick per item.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals                      | Content
// s_      | in        | s_tvalid s_tready s_tdata    | one control tick
// m_      | out       | m_tvalid m_tready m_tdata    | phase, armed, hold time
// cfg_    | in        | cfg_we cfg_addr cfg_wdata    | register writes
//
// An item is registered in the input stage on acceptance and its result in the
// output stage when it advances. One item is accepted every cycle while the output
// is not stalled; the state update is a single pass through the compare logic and
// the 21-bit hold-time adder between the two registers. Reset is synchronous and
// returns state and registers to their defaults. A stalled output holds the
// pipeline, and the input stalls only when both stages are full.
// ----------------------------------------------------------------------------
module step_dock_impact_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // dock_requested, on_ground, speed_reliable, forward_speed, heading_err,
    // left_length, right_length, impact_window_ok, left_rate_delta,
    // right_rate_delta, wheel_imu_mismatch, tick_length, zero fill
    input  logic [sdis_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // task_phase, armed, hold_elapsed, zero fill
    output logic [sdis_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [sdis_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sdis_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [sdis_pkg::LEN_W-1:0]          prepare_length_reg;
    logic [sdis_pkg::LEN_W-1:0]          length_tolerance_reg;
    logic [sdis_pkg::HEAD_TOL_W-1:0]     heading_tolerance_reg;
    logic signed [sdis_pkg::SPEED_W-1:0] min_forward_speed_reg;
    logic [sdis_pkg::LIMIT_W-1:0]        rate_delta_limit_reg;
    logic [sdis_pkg::LIMIT_W-1:0]        mismatch_limit_reg;
    logic [sdis_pkg::HOLD_W-1:0]         confirm_time_reg;

    logic                          in_valid_reg;
    sdis_pkg::in_item_t            in_item_reg;
    logic                          out_valid_reg;
    sdis_pkg::out_item_t           out_item_reg;

    logic [sdis_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic                          armed_reg, armed_next;
    logic [sdis_pkg::HOLD_W-1:0]   hold_reg, hold_next;

    logic                          out_free;
    logic                          advance;
    logic                          ready_cond;
    logic                          cand;
    logic [sdis_pkg::LIMIT_W-1:0]  left_abs, right_abs, rate_max;
    logic [sdis_pkg::HOLD_W:0]     hold_sum;
    logic [sdis_pkg::HOLD_W-1:0]   hold_sat;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prepare_length_reg    <= sdis_pkg::RST_PREPARE_LENGTH;
            length_tolerance_reg  <= sdis_pkg::RST_LENGTH_TOLERANCE;
            heading_tolerance_reg <= sdis_pkg::RST_HEADING_TOLERANCE;
            min_forward_speed_reg <= sdis_pkg::RST_MIN_FORWARD_SPEED;
            rate_delta_limit_reg  <= sdis_pkg::RST_RATE_DELTA_LIMIT;
            mismatch_limit_reg    <= sdis_pkg::RST_MISMATCH_LIMIT;
            confirm_time_reg      <= sdis_pkg::RST_CONFIRM_TIME;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                sdis_pkg::REG_PREPARE_LENGTH:
                    prepare_length_reg <= cfg_wdata[sdis_pkg::LEN_W-1:0];
                sdis_pkg::REG_LENGTH_TOLERANCE:
                    length_tolerance_reg <= cfg_wdata[sdis_pkg::LEN_W-1:0];
                sdis_pkg::REG_HEADING_TOLERANCE:
                    heading_tolerance_reg <= cfg_wdata[sdis_pkg::HEAD_TOL_W-1:0];
                sdis_pkg::REG_MIN_FORWARD_SPEED:
                    min_forward_speed_reg <= cfg_wdata[sdis_pkg::SPEED_W-1:0];
                sdis_pkg::REG_RATE_DELTA_LIMIT:
                    rate_delta_limit_reg <= cfg_wdata[sdis_pkg::LIMIT_W-1:0];
                sdis_pkg::REG_MISMATCH_LIMIT:
                    mismatch_limit_reg <= cfg_wdata[sdis_pkg::LIMIT_W-1:0];
                sdis_pkg::REG_CONFIRM_TIME:
                    confirm_time_reg <= cfg_wdata[sdis_pkg::HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        left_abs  = sdis_pkg::abs16(in_item_reg.left_rate_delta);
        right_abs = sdis_pkg::abs16(in_item_reg.right_rate_delta);
        rate_max  = (left_abs > right_abs) ? left_abs : right_abs;

        ready_cond = in_item_reg.on_ground && in_item_reg.speed_reliable &&
            (in_item_reg.forward_speed >= min_forward_speed_reg) &&
            (sdis_pkg::abs13(in_item_reg.heading_err) <= heading_tolerance_reg) &&
            (sdis_pkg::len_diff(in_item_reg.left_length, prepare_length_reg)
                <= length_tolerance_reg) &&
            (sdis_pkg::len_diff(in_item_reg.right_length, prepare_length_reg)
                <= length_tolerance_reg);

        cand = in_item_reg.impact_window_ok && (rate_max > rate_delta_limit_reg) &&
            (sdis_pkg::abs16(in_item_reg.wheel_imu_mismatch) > mismatch_limit_reg);

        hold_sum = {1'b0, hold_reg} +
            {{(sdis_pkg::HOLD_W + 1 - sdis_pkg::TICK_W){1'b0}}, in_item_reg.tick_length};
        hold_sat = hold_sum[sdis_pkg::HOLD_W] ? sdis_pkg::HOLD_MAX
                                              : hold_sum[sdis_pkg::HOLD_W-1:0];

        phase_next = phase_reg;
        armed_next = armed_reg;
        hold_next  = hold_reg;
        unique case (phase_reg)
            sdis_pkg::PHASE_INACTIVE: begin
                if (in_item_reg.dock_requested) begin
                    phase_next = sdis_pkg::PHASE_PREPARE;
                end
            end
            sdis_pkg::PHASE_PREPARE: begin
                if (!in_item_reg.dock_requested) begin
                    phase_next = sdis_pkg::PHASE_INACTIVE;
                    armed_next = 1'b0;
                    hold_next  = '0;
                end else begin
                    armed_next = ready_cond;
                    if (ready_cond && cand) begin
                        hold_next = hold_sat;
                        if (hold_sat >= confirm_time_reg) begin
                            phase_next = sdis_pkg::PHASE_PASSIVE;
                            armed_next = 1'b0;
                        end
                    end else begin
                        hold_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= sdis_pkg::PHASE_INACTIVE;
            armed_reg     <= 1'b0;
            hold_reg      <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                armed_reg     <= armed_next;
                hold_reg      <= hold_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_tdata;
        end
        if (advance) begin
            out_item_reg.pad          <= 1'b0;
            out_item_reg.task_phase   <= phase_next;
            out_item_reg.armed        <= armed_next;
            out_item_reg.hold_elapsed <= hold_next;
        end
    end

endmodule
